>>> rtl/lbpt_pkg.sv
// shared types and constants for the lamp blink and pulse timer
`default_nettype none

package lbpt_pkg;

	// field widths
	localparam int unsigned REQ_W    = 3;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned DUTY_W   = 8;
	localparam int unsigned ACT_W    = 16;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned PLEN_W   = 16;
	localparam int unsigned LIMIT_W  = 24;
	localparam int unsigned PROD_W   = 24;

	// serial remainder: one quotient bit per cycle
	localparam int unsigned REM_STEPS = TIME_W;
	localparam int unsigned REM_CNT_W = $clog2(REM_STEPS);

	// constants of the lamp behaviour
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;
	localparam logic [DUTY_W-1:0]   DUTY_DEFAULT = 8'd50;
	localparam logic [PROD_W-1:0]   PCT_SCALE    = 24'd100;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_BLINK  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_INVERT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_PULSE  = 3'd4;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF   = 2'd0,
		MODE_ON    = 2'd1,
		MODE_BLINK = 2'd2
	} lbpt_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MOD,
		ST_MUL,
		ST_FIN
	} lbpt_state_t;

endpackage

`default_nettype wire

>>> rtl/lbpt_req_if.sv
// request channel carrying one lamp command
`default_nettype none

interface lbpt_req_if
	import lbpt_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [TIME_W-1:0]   now_ms;
	logic [MODE_W-1:0]   light_mode;
	logic [PERIOD_W-1:0] blink_period;
	logic [DUTY_W-1:0]   duty_percent;
	logic [ACT_W-1:0]    active_time;
	logic [COUNT_W-1:0]  blink_count;
	logic [PLEN_W-1:0]   pulse_len;

	modport source (
		output valid, req_type, now_ms, light_mode, blink_period,
		       duty_percent, active_time, blink_count, pulse_len,
		input  ready
	);

	modport sink (
		input  valid, req_type, now_ms, light_mode, blink_period,
		       duty_percent, active_time, blink_count, pulse_len,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/lbpt_res_if.sv
// result channel carrying the lamp level
`default_nettype none

interface lbpt_res_if;
	logic valid;
	logic ready;
	logic lamp_on;
	logic changed;

	modport source (output valid, lamp_on, changed, input ready);
	modport sink (input valid, lamp_on, changed, output ready);
endinterface

`default_nettype wire

>>> rtl/lamp_blink_pulse_timer_unit.sv
// Lamp controller: each request applies one command (tick, set mode, blink, invert, pulse) at
// its millisecond time stamp and then updates the lamp, giving one result with the lamp level
// and a changed flag. Requests are taken one at a time. A request goes from acceptance through
// the prepare and finish states; if the lamp is in blink mode with a nonzero period, the
// remainder and multiply states come between: the blink phase needs the elapsed time modulo
// the period, worked out bit-serially at one bit per cycle. A new request is accepted as soon
// as the previous one has produced its result, even while that result still waits to be taken.
// The default blink period register resets to 500 and may be written while the block is idle.
`default_nettype none

module lamp_blink_pulse_timer_unit
	import lbpt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	lbpt_req_if.sink                 req,
	lbpt_res_if.source               res,
	input  wire logic                cfg_we,
	input  wire logic [PERIOD_W-1:0] cfg_wdata
);

	lbpt_state_t state_q, state_n;

	// configuration
	logic [PERIOD_W-1:0] dflt_period_q;

	// lamp state
	logic                lit_q;
	lbpt_mode_t          mode_q;
	logic [PERIOD_W-1:0] period_q;
	logic [DUTY_W-1:0]   duty_q;
	logic [TIME_W-1:0]   start_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic                pend_q;
	logic [TIME_W-1:0]   pstart_q;
	logic [PLEN_W-1:0]   plen_q;

	// per-request working registers
	logic [TIME_W-1:0]   now_q;
	logic                before_q;
	logic [PERIOD_W-1:0] t_q;
	logic [PROD_W-1:0]   t_prod_q;
	logic [PROD_W-1:0]   d_prod_q;

	// result register
	logic res_valid_q;
	logic lamp_on_q;
	logic changed_q;

	// command decode
	logic                accept;
	logic                do_set;
	lbpt_mode_t          set_mode;
	logic [ACT_W-1:0]    set_act;
	logic                lit_n;
	lbpt_mode_t          mode_n;
	logic [PERIOD_W-1:0] period_n;
	logic [DUTY_W-1:0]   duty_n;
	logic [TIME_W-1:0]   start_n;
	logic [LIMIT_W-1:0]  limit_n;
	logic                pend_n;
	logic [TIME_W-1:0]   pstart_n;
	logic [PLEN_W-1:0]   plen_n;

	// update stage
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] pulse_elapsed;
	logic              lit_b;
	logic              lit_p;
	logic              pulse_fire;
	logic              lim_fire;
	logic              lit_f;
	logic              fin_go;

	// remainder unit
	logic                rem_start;
	logic                rem_done;
	logic [PERIOD_W-1:0] rem_val;

	assign accept = req.valid && req.ready;
	assign elapsed       = now_q - start_q;
	assign pulse_elapsed = now_q - pstart_q;

	// apply the command to the lamp state
	always_comb begin
		do_set   = 1'b0;
		set_mode = MODE_OFF;
		set_act  = '0;
		lit_n    = lit_q;
		mode_n   = mode_q;
		period_n = period_q;
		duty_n   = duty_q;
		start_n  = start_q;
		limit_n  = limit_q;
		pend_n   = pend_q;
		pstart_n = pstart_q;
		plen_n   = plen_q;
		case (req.req_type)
			REQ_SET: begin
				if (req.light_mode <= MODE_W'(MODE_BLINK)) begin
					do_set   = 1'b1;
					set_mode = lbpt_mode_t'(req.light_mode);
					set_act  = req.active_time;
				end
			end
			REQ_BLINK: begin
				do_set   = 1'b1;
				set_mode = MODE_BLINK;
			end
			REQ_INVERT: begin
				if (mode_q == MODE_ON) begin
					do_set   = 1'b1;
					set_mode = MODE_OFF;
				end else if (mode_q == MODE_OFF) begin
					do_set   = 1'b1;
					set_mode = MODE_ON;
				end
			end
			REQ_PULSE: begin
				plen_n   = req.pulse_len;
				pend_n   = 1'b1;
				pstart_n = req.now_ms;
				lit_n    = !lit_q;
			end
			default: begin
			end
		endcase
		if (do_set) begin
			lit_n  = (set_mode != MODE_OFF);
			mode_n = set_mode;
			if (set_mode == MODE_ON && mode_q != MODE_ON) begin
				start_n = req.now_ms;
				limit_n = LIMIT_W'(set_act);
			end
			if (set_mode == MODE_BLINK) begin
				period_n = (req.blink_period == '0) ? dflt_period_q : req.blink_period;
				duty_n   = (req.duty_percent == '0) ? DUTY_DEFAULT : req.duty_percent;
				if (mode_q != MODE_BLINK) begin
					start_n = req.now_ms;
				end
			end
		end
		if (req.req_type == REQ_BLINK) begin
			limit_n = LIMIT_W'(req.blink_period) * LIMIT_W'(req.blink_count);
		end
	end

	// update at the request time: blink phase, pulse end, active limit
	always_comb begin
		lit_b = lit_q;
		if (mode_q == MODE_BLINK) begin
			if (period_q == '0) begin
				lit_b = (duty_q != '0);
			end else begin
				lit_b = (t_prod_q < d_prod_q);
			end
		end
		pulse_fire = pend_q && (pulse_elapsed > TIME_W'(plen_q));
		lit_p      = pulse_fire ? !lit_b : lit_b;
		lim_fire   = lit_p && (limit_q != '0) && (elapsed >= TIME_W'(limit_q));
		lit_f      = lim_fire ? 1'b0 : lit_p;
	end

	assign fin_go    = (state_q == ST_FIN) && (!res_valid_q || res.ready);
	assign rem_start = (state_q == ST_PREP) && (mode_q == MODE_BLINK) && (period_q != '0);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_n = ST_PREP;
				end
			end
			ST_PREP: begin
				state_n = rem_start ? ST_MOD : ST_FIN;
			end
			ST_MOD: begin
				if (rem_done) begin
					state_n = ST_MUL;
				end
			end
			ST_MUL: begin
				state_n = ST_FIN;
			end
			ST_FIN: begin
				if (fin_go) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			dflt_period_q <= cfg_wdata;
		end
	end

	// lamp state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q    <= 1'b0;
			mode_q   <= MODE_OFF;
			period_q <= PERIOD_RESET;
			duty_q   <= DUTY_DEFAULT;
			start_q  <= '0;
			limit_q  <= '0;
			pend_q   <= 1'b0;
			pstart_q <= '0;
			plen_q   <= '0;
		end else if (accept) begin
			lit_q    <= lit_n;
			mode_q   <= mode_n;
			period_q <= period_n;
			duty_q   <= duty_n;
			start_q  <= start_n;
			limit_q  <= limit_n;
			pend_q   <= pend_n;
			pstart_q <= pstart_n;
			plen_q   <= plen_n;
		end else if (fin_go) begin
			lit_q <= lit_f;
			if (pulse_fire) begin
				pend_q <= 1'b0;
			end
			if (lim_fire) begin
				limit_q <= '0;
				mode_q  <= MODE_OFF;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= req.now_ms;
			before_q <= lit_q;
		end
		if (rem_done) begin
			t_q <= rem_val;
		end
		if (state_q == ST_MUL) begin
			t_prod_q <= PROD_W'(t_q) * PCT_SCALE;
			d_prod_q <= PROD_W'(duty_q) * PROD_W'(period_q);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			lamp_on_q   <= 1'b0;
			changed_q   <= 1'b0;
		end else if (fin_go) begin
			res_valid_q <= 1'b1;
			lamp_on_q   <= lit_f;
			changed_q   <= (lit_f != before_q);
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	lbpt_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (elapsed),
		.divisor  (period_q),
		.done     (rem_done),
		.rem      (rem_val)
	);

	assign req.ready   = (state_q == ST_IDLE);
	assign res.valid   = res_valid_q;
	assign res.lamp_on = lamp_on_q;
	assign res.changed = changed_q;

endmodule

`default_nettype wire

>>> rtl/lbpt_rem.sv
// bit-serial restoring remainder of a time span by the blink period
`default_nettype none

module lbpt_rem
	import lbpt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [TIME_W-1:0]   dividend,
	input  wire logic [PERIOD_W-1:0] divisor,
	output logic                     done,
	output logic [PERIOD_W-1:0]      rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [REM_CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]    dvd_q;
	logic [PERIOD_W-1:0]  rem_q;
	logic [PERIOD_W-1:0]  div_q;
	logic [PERIOD_W:0]    trial;
	logic [PERIOD_W:0]    trial_sub;

	// one trial subtraction per cycle, top bit of the difference is the borrow
	always_comb begin
		trial     = {rem_q, dvd_q[TIME_W-1]};
		trial_sub = trial - {1'b0, div_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == REM_CNT_W'(REM_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			if (trial_sub[PERIOD_W]) begin
				rem_q <= trial[PERIOD_W-1:0];
			end else begin
				rem_q <= trial_sub[PERIOD_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

>>> sim/testbench.sv
// testbench for the lamp blink and pulse timer: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module testbench;
	import lbpt_pkg::*;

	// mode code with no meaning and request codes that act as a tick
	localparam logic [MODE_W-1:0] MODE_CODE_SPARE = 2'd3;
	localparam logic [REQ_W-1:0]  REQ_SPARE_LO    = 3'd5;
	localparam logic [REQ_W-1:0]  REQ_SPARE_HI    = 3'd7;

	localparam int STALL_LIMIT  = 1000;
	localparam int SETTLE_CYCLES = 60;
	localparam int ITEMS_PER_PHASE = 240;

	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [TIME_W-1:0]   now_ms;
		logic [MODE_W-1:0]   light_mode;
		logic [PERIOD_W-1:0] blink_period;
		logic [DUTY_W-1:0]   duty_percent;
		logic [ACT_W-1:0]    active_time;
		logic [COUNT_W-1:0]  blink_count;
		logic [PLEN_W-1:0]   pulse_len;
	} lamp_cmd_t;

	typedef struct packed {
		logic lamp_on;
		logic changed;
	} lamp_level_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [PERIOD_W-1:0] cfg_wdata;

	lbpt_req_if req_if ();
	lbpt_res_if res_if ();

	lamp_blink_pulse_timer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// lamp state as the predictor sees it
	logic                lamp_lit;
	lbpt_mode_t          lamp_mode;
	logic [PERIOD_W-1:0] cur_period;
	logic [DUTY_W-1:0]   cur_duty;
	logic [TIME_W-1:0]   run_start;
	logic [LIMIT_W-1:0]  auto_off_limit;
	logic                pulse_armed;
	logic [TIME_W-1:0]   pulse_t0;
	logic [PLEN_W-1:0]   pulse_hold;
	logic [PERIOD_W-1:0] dflt_period;

	lamp_level_t       lamp_expect_q[$];
	logic [TIME_W-1:0] ms_now;
	int                send_idle_pct;
	int                recv_idle_pct;
	int                mismatches;
	int                quiet_cycles;
	int                n_requests;
	int                n_levels;
	int                n_toggles;
	int                n_cfg_writes;

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void reset_predictor();
		lamp_lit       = 1'b0;
		lamp_mode      = MODE_OFF;
		cur_period     = PERIOD_RESET;
		cur_duty       = DUTY_DEFAULT;
		run_start      = '0;
		auto_off_limit = '0;
		pulse_armed    = 1'b0;
		pulse_t0       = '0;
		pulse_hold     = '0;
		dflt_period    = PERIOD_RESET;
	endfunction

	// mode change as done by set, blink and invert
	function automatic void enter_mode(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] t_now,
			input logic [PERIOD_W-1:0] per, input logic [DUTY_W-1:0] duty,
			input logic [ACT_W-1:0] act);
		if (m == MODE_CODE_SPARE)
			return;
		lamp_lit = (m != MODE_OFF);
		if (m == MODE_ON && lamp_mode != MODE_ON) begin
			run_start      = t_now;
			auto_off_limit = {8'd0, act};
		end
		if (m == MODE_BLINK) begin
			cur_period = (per == '0) ? dflt_period : per;
			cur_duty   = (duty == '0) ? DUTY_DEFAULT : duty;
			if (lamp_mode != MODE_BLINK)
				run_start = t_now;
		end
		lamp_mode = lbpt_mode_t'(m);
	endfunction

	// apply one command, then the time update, and give the lamp level
	function automatic lamp_level_t predict_lamp(input lamp_cmd_t c);
		lamp_level_t       lvl;
		logic              was_lit;
		logic [31:0]       period32;
		logic [31:0]       rem;
		logic [31:0]       phase;
		logic [TIME_W-1:0] since_start;
		logic [TIME_W-1:0] since_pulse;
		was_lit = lamp_lit;
		case (c.req_type)
			REQ_SET: begin
				enter_mode(c.light_mode, c.now_ms, c.blink_period, c.duty_percent, c.active_time);
			end
			REQ_BLINK: begin
				enter_mode(MODE_BLINK, c.now_ms, c.blink_period, c.duty_percent, '0);
				auto_off_limit = {8'd0, c.blink_period} * {16'd0, c.blink_count};
			end
			REQ_INVERT: begin
				if (lamp_mode == MODE_ON)
					enter_mode(MODE_OFF, c.now_ms, '0, '0, '0);
				else if (lamp_mode == MODE_OFF)
					enter_mode(MODE_ON, c.now_ms, '0, '0, '0);
			end
			REQ_PULSE: begin
				pulse_hold  = c.pulse_len;
				pulse_armed = 1'b1;
				pulse_t0    = c.now_ms;
				lamp_lit    = !lamp_lit;
			end
			default: ;
		endcase

		// blink phase: a zero period counts as phase zero
		if (lamp_mode == MODE_BLINK) begin
			phase = '0;
			period32 = {16'd0, cur_period};
			if (period32 != '0) begin
				rem   = (c.now_ms - run_start) % period32;
				phase = (rem * 32'd100) / period32;
			end
			lamp_lit = (phase < {24'd0, cur_duty});
		end

		// pulse toggles back once its length is strictly exceeded
		since_pulse = c.now_ms - pulse_t0;
		if (pulse_armed && since_pulse > {16'd0, pulse_hold}) begin
			pulse_armed = 1'b0;
			lamp_lit    = !lamp_lit;
		end

		// auto off once the active limit has elapsed
		since_start = c.now_ms - run_start;
		if (lamp_lit && auto_off_limit != '0 && since_start >= {8'd0, auto_off_limit}) begin
			auto_off_limit = '0;
			lamp_mode      = MODE_OFF;
			lamp_lit       = 1'b0;
		end

		lvl.lamp_on = lamp_lit;
		lvl.changed = (lamp_lit != was_lit);
		return lvl;
	endfunction

	function automatic lamp_cmd_t mk_cmd(input logic [REQ_W-1:0] rt, input logic [TIME_W-1:0] t,
			input logic [MODE_W-1:0] lm, input logic [PERIOD_W-1:0] per,
			input logic [DUTY_W-1:0] duty, input logic [ACT_W-1:0] act,
			input logic [COUNT_W-1:0] cnt, input logic [PLEN_W-1:0] plen);
		lamp_cmd_t c;
		c.req_type     = rt;
		c.now_ms       = t;
		c.light_mode   = lm;
		c.blink_period = per;
		c.duty_percent = duty;
		c.active_time  = act;
		c.blink_count  = cnt;
		c.pulse_len    = plen;
		return c;
	endfunction

	// random request: time mostly creeps forward, now and then jumps or wraps
	function automatic lamp_cmd_t random_cmd();
		lamp_cmd_t   c;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8)
			ms_now = $urandom;
		else if (pick < 15)
			ms_now += $urandom_range(70000, 0);
		else if (pick < 45)
			ms_now += $urandom_range(1000, 0);
		else
			ms_now += $urandom_range(40, 0);
		c.now_ms = ms_now;

		pick = $urandom_range(99);
		if (pick < 38)
			c.req_type = REQ_TICK;
		else if (pick < 58)
			c.req_type = REQ_SET;
		else if (pick < 72)
			c.req_type = REQ_BLINK;
		else if (pick < 82)
			c.req_type = REQ_INVERT;
		else if (pick < 94)
			c.req_type = REQ_PULSE;
		else
			c.req_type = 3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));

		c.light_mode = ($urandom_range(99) < 8) ? MODE_CODE_SPARE : 2'($urandom_range(2, 0));

		pick = $urandom_range(99);
		if (pick < 10)
			c.blink_period = '0;
		else if (pick < 20)
			c.blink_period = 16'($urandom);
		else
			c.blink_period = 16'($urandom_range(120, 1));

		c.duty_percent = ($urandom_range(99) < 15) ? 8'($urandom) : 8'($urandom_range(100, 0));

		pick = $urandom_range(99);
		if (pick < 50)
			c.active_time = '0;
		else if (pick < 90)
			c.active_time = 16'($urandom_range(600, 1));
		else
			c.active_time = 16'($urandom);

		pick = $urandom_range(99);
		if (pick < 40)
			c.blink_count = '0;
		else if (pick < 90)
			c.blink_count = 8'($urandom_range(10, 1));
		else
			c.blink_count = 8'($urandom);

		pick = $urandom_range(99);
		if (pick < 60)
			c.pulse_len = 16'($urandom_range(100, 0));
		else if (pick < 90)
			c.pulse_len = 16'($urandom_range(2000, 0));
		else
			c.pulse_len = 16'($urandom);
		return c;
	endfunction

	// send one request; valid stays high when the next one follows at once
	task automatic send_request(input lamp_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.req_type     <= c.req_type;
		req_if.now_ms       <= c.now_ms;
		req_if.light_mode   <= c.light_mode;
		req_if.blink_period <= c.blink_period;
		req_if.duty_percent <= c.duty_percent;
		req_if.active_time  <= c.active_time;
		req_if.blink_count  <= c.blink_count;
		req_if.pulse_len    <= c.pulse_len;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		lamp_expect_q.push_back(predict_lamp(c));
		n_requests++;
	endtask

	// wait until every expected level has come back and the block is idle
	task automatic drain_levels();
		req_if.valid <= 1'b0;
		while (lamp_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_default_period(input logic [PERIOD_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we      <= 1'b0;
		dflt_period = v;
		n_cfg_writes++;
	endtask

	// steady modes, invert, the spare mode code and spare request codes
	task automatic test_modes_and_invert();
		ms_now = '0;
		send_request(mk_cmd(REQ_TICK, 32'd0, MODE_OFF, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_SET, 32'd10, MODE_ON, '1, '1, '0, '1, '1));
		send_request(mk_cmd(REQ_INVERT, 32'd20, MODE_OFF, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_INVERT, 32'd30, MODE_OFF, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_SET, 32'd40, MODE_CODE_SPARE, '1, '1, '1, '1, '1));
		send_request(mk_cmd(REQ_SPARE_LO, 32'd50, MODE_BLINK, '1, '1, '1, '1, '1));
		send_request(mk_cmd(REQ_SPARE_HI, 32'd60, MODE_BLINK, '0, '0, '0, '0, '0));
	endtask

	// blink with defaults, extreme period and duty across the time wrap, full duty
	task automatic test_blink_extremes();
		send_request(mk_cmd(REQ_SET, 32'd100, MODE_BLINK, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_TICK, 32'd400, MODE_OFF, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_BLINK, 32'hFFFF_FF00, MODE_OFF, '1, '1, '0, '1, '0));
		send_request(mk_cmd(REQ_TICK, 32'h0000_0100, MODE_OFF, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_INVERT, 32'h0000_0200, MODE_OFF, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_SET, 32'h0000_0300, MODE_BLINK, 16'd3, 8'd100, '0, '0, '0));
		ms_now = 32'h0000_0300;
	endtask

	// pulses of zero and full length, and auto off at the largest active time
	task automatic test_pulse_and_auto_off();
		logic [TIME_W-1:0] t0;
		t0 = ms_now + 32'd1000;
		send_request(mk_cmd(REQ_SET, t0, MODE_ON, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_PULSE, t0 + 32'd5, MODE_OFF, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_TICK, t0 + 32'd6, MODE_OFF, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_PULSE, t0 + 32'd10, MODE_OFF, '0, '0, '0, '0, '1));
		send_request(mk_cmd(REQ_TICK, t0 + 32'd65545, MODE_OFF, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_TICK, t0 + 32'd65546, MODE_OFF, '0, '0, '0, '0, '0));
		t0 = t0 + 32'd100000;
		send_request(mk_cmd(REQ_SET, t0, MODE_OFF, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_SET, t0 + 32'd1, MODE_ON, '0, '0, '1, '0, '0));
		send_request(mk_cmd(REQ_TICK, t0 + 32'd65535, MODE_OFF, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_TICK, t0 + 32'd65536, MODE_OFF, '0, '0, '0, '0, '0));
		ms_now = t0 + 32'd65536;
	endtask

	// default period of zero: blink lamp lit all the time
	task automatic test_zero_period();
		drain_levels();
		write_default_period('0);
		send_request(mk_cmd(REQ_SET, ms_now + 32'd7, MODE_BLINK, '0, '0, '0, '0, '0));
		send_request(mk_cmd(REQ_BLINK, ms_now + 32'd900, MODE_OFF, '0, 8'd1, '0, 8'd5, '0));
		ms_now = ms_now + 32'd900;
	endtask

	task automatic test_random_traffic(input int n, input int s_pct, input int r_pct,
			input logic [PERIOD_W-1:0] period);
		drain_levels();
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		write_default_period(period);
		repeat (n) send_request(random_cmd());
	endtask

	// result side: random stall, compare each level with the oldest expectation
	always @(posedge clk) begin
		lamp_level_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			n_levels++;
			if (res_if.changed === 1'b1)
				n_toggles++;
			if (lamp_expect_q.size() == 0) begin
				$display("%0t unexpected level: lamp_on %b changed %b", $time,
					res_if.lamp_on, res_if.changed);
				mismatches++;
			end else begin
				want = lamp_expect_q.pop_front();
				if (res_if.lamp_on !== want.lamp_on) begin
					$display("%0t lamp_on mismatch: expected %b, got %b", $time,
						want.lamp_on, res_if.lamp_on);
					mismatches++;
				end
				if (res_if.changed !== want.changed) begin
					$display("%0t changed mismatch: expected %b, got %b", $time,
						want.changed, res_if.changed);
					mismatches++;
				end
			end
		end
		res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t watchdog: no handshake for %0d cycles, %0d levels outstanding",
					$time, STALL_LIMIT, lamp_expect_q.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_if.valid        = 1'b0;
		req_if.req_type     = REQ_TICK;
		req_if.now_ms       = '0;
		req_if.light_mode   = MODE_OFF;
		req_if.blink_period = '0;
		req_if.duty_percent = '0;
		req_if.active_time  = '0;
		req_if.blink_count  = '0;
		req_if.pulse_len    = '0;
		res_if.ready        = 1'b0;
		send_idle_pct       = 8;
		recv_idle_pct       = 45;
		mismatches          = 0;
		quiet_cycles        = 0;
		n_requests          = 0;
		n_levels            = 0;
		n_toggles           = 0;
		n_cfg_writes        = 0;
		reset_predictor();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_modes_and_invert();
		test_blink_extremes();
		test_pulse_and_auto_off();
		test_zero_period();
		test_random_traffic(ITEMS_PER_PHASE, 8, 45, 16'($urandom_range(2000, 1)));
		test_random_traffic(ITEMS_PER_PHASE, 45, 8, '1);
		test_random_traffic(ITEMS_PER_PHASE, 0, 0, 16'd1);
		drain_levels();

		if (lamp_expect_q.size() != 0) begin
			$display("%0d expected levels never arrived", lamp_expect_q.size());
			mismatches++;
		end
		$display("run covered %0d requests and %0d lamp levels, %0d of them changes",
			n_requests, n_levels, n_toggles);
		$display("default period written %0d times, %0d mismatches", n_cfg_writes, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
